/* hw/rtl/hkeq_pkg.sv */
// ----------------------------------------------------------------------------
// hkeq_pkg: shared types and constants of the keyboard event queue
// Holds the command format between the front and back parts, the state
// encodings and the modifier decoding helpers.
// ----------------------------------------------------------------------------
package hkeq_pkg;

	// Default depth of the event ring; it keeps at most one entry less.
	localparam int QUEUE_DEPTH_DEF = 32;

	// Keycode slots in one boot report.
	localparam int KEY_SLOTS = 6;

	// Depth of the command queue between the front and back parts.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	// Scan steps of one report: six modifier checks, six releases, six presses.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_REL_FIRST = 5'd6;
	localparam logic [STEP_W-1:0] STEP_PRS_FIRST = 5'd12;
	localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

	// Merged modifier keycodes.
	localparam logic [7:0] CODE_CTRL = 8'hE0;
	localparam logic [7:0] CODE_SHIFT = 8'hE1;
	localparam logic [7:0] CODE_ALT = 8'hE2;

	// Left and right bits of each merged modifier.
	localparam logic [7:0] MASK_CTRL = 8'h11;
	localparam logic [7:0] MASK_SHIFT = 8'h22;
	localparam logic [7:0] MASK_ALT = 8'h44;

	// Modifier groups in the order their events are produced.
	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_CTRL = 2'd1;
	localparam logic [1:0] GRP_ALT = 2'd2;

	// Input selector values.
	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_POP = 1'b1;

	typedef logic [KEY_SLOTS-1:0][7:0] key_set_t;

	typedef enum logic [1:0] {
		CMD_EVENT,
		CMD_DONE,
		CMD_POP
	} cmd_kind_t;

	// One command from the front part to the back part.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] code;
		logic       down;
	} cmd_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SCAN,
		FR_DONE,
		FR_POP
	} front_state_t;

	typedef enum logic {
		BK_RUN,
		BK_READ
	} back_state_t;

	// True when any slot of the set holds the given code.
	function automatic logic holds_key(input key_set_t keys, input logic [7:0] code);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit = hit | (keys[i] == code);
		end
		return hit;
	endfunction

	function automatic logic [7:0] group_mask(input logic [1:0] grp);
		logic [7:0] m;
		case (grp)
			GRP_SHIFT: m = MASK_SHIFT;
			GRP_CTRL:  m = MASK_CTRL;
			GRP_ALT:   m = MASK_ALT;
			default:   m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] group_code(input logic [1:0] grp);
		logic [7:0] c;
		case (grp)
			GRP_SHIFT: c = CODE_SHIFT;
			GRP_CTRL:  c = CODE_CTRL;
			GRP_ALT:   c = CODE_ALT;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/hkeq_front.sv */
// ----------------------------------------------------------------------------
// hkeq_front: request intake and report scan
// Accepts one request at a time. A report is compared with the previous one
// over eighteen scan steps, and every event found goes to the command queue,
// followed by a completion command. A pop becomes a single pop command.
// ----------------------------------------------------------------------------
module hkeq_front
	import hkeq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_action,
	input  logic [7:0]  in_mods,
	input  key_set_t    in_keys,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	front_state_t     state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [7:0]       rep_mods_q;
	key_set_t         rep_keys_q;
	logic [7:0]       prev_mods_q;
	key_set_t         prev_keys_q;

	logic             accept;
	logic             step_adv;
	logic             commit;
	logic             cand_valid;
	logic [7:0]       cand_code;
	logic             cand_down;
	logic [7:0]       gone;
	logic [7:0]       came;
	logic [2:0]       slot;
	logic [7:0]       key;

	assign accept = in_valid && in_ready;
	assign gone = prev_mods_q & ~rep_mods_q;
	assign came = rep_mods_q & ~prev_mods_q;

	// Event candidate of the current scan step.
	always_comb begin
		cand_valid = 1'b0;
		cand_code = 8'h00;
		cand_down = 1'b0;
		slot = 3'd0;
		key = 8'h00;
		case (step_q) inside
			[5'd0:5'd5]: begin
				cand_code = group_code(step_q[2:1]);
				cand_down = step_q[0];
				cand_valid = |((step_q[0] ? came : gone) & group_mask(step_q[2:1]));
			end
			[STEP_REL_FIRST:STEP_PRS_FIRST-5'd1]: begin
				slot = 3'(step_q - STEP_REL_FIRST);
				key = prev_keys_q[slot];
				cand_code = key;
				cand_valid = (key != 8'h00) && !holds_key(rep_keys_q, key);
			end
			[STEP_PRS_FIRST:STEP_LAST]: begin
				slot = 3'(step_q - STEP_PRS_FIRST);
				key = rep_keys_q[slot];
				cand_code = key;
				cand_down = 1'b1;
				cand_valid = (key != 8'h00) && !holds_key(prev_keys_q, key);
			end
			default: begin
				cand_valid = 1'b0;
			end
		endcase
	end

	// Next state and command output.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd_valid = 1'b0;
		cmd = '{kind: CMD_EVENT, code: cand_code, down: cand_down};
		step_adv = 1'b0;
		commit = 1'b0;
		case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (in_action == ACT_POP) ? FR_POP : FR_SCAN;
				end
			end
			FR_SCAN: begin
				cmd_valid = cand_valid;
				step_adv = !cand_valid || cmd_ready;
				if (step_adv && step_q == STEP_LAST) begin
					state_d = FR_DONE;
				end
			end
			FR_DONE: begin
				cmd_valid = 1'b1;
				cmd = '{kind: CMD_DONE, code: 8'h00, down: 1'b0};
				if (cmd_ready) begin
					commit = 1'b1;
					state_d = FR_IDLE;
				end
			end
			FR_POP: begin
				cmd_valid = 1'b1;
				cmd = '{kind: CMD_POP, code: 8'h00, down: 1'b0};
				if (cmd_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q <= '0;
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (step_adv) begin
				step_q <= step_q + 5'd1;
			end
			// The finished report becomes the previous one.
			if (commit) begin
				prev_mods_q <= rep_mods_q;
				prev_keys_q <= rep_keys_q;
			end
		end
	end

	// Report holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rep_mods_q <= in_mods;
			rep_keys_q <= in_keys;
		end
	end

endmodule

/* hw/rtl/hkeq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// hkeq_cmd_fifo: command queue between front and back parts
// A small first-in first-out queue of commands so that the scan and the
// event ring can stall independently.
// ----------------------------------------------------------------------------
module hkeq_cmd_fifo
	import hkeq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != (CMD_PTR_W+1)'(CMD_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/hkeq_back.sv */
// ----------------------------------------------------------------------------
// hkeq_back: event ring and result register
// Executes commands in order: events are written into the ring unless it is
// full, a completion gives the result of a report, and a pop reads the oldest
// event through the registered memory port, or an empty result if there is none.
// ----------------------------------------------------------------------------
module hkeq_back
	import hkeq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_event_valid,
	output logic [7:0] out_code,
	output logic       out_down,
	output logic       out_pending
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [8:0]       mem [QUEUE_DEPTH];
	logic [8:0]       rd_data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	back_state_t      state_q, state_d;

	logic             out_valid_q;
	logic             out_event_valid_q;
	logic [7:0]       out_code_q;
	logic             out_down_q;
	logic             out_pending_q;

	logic             out_free;
	logic             ring_empty;
	logic             ring_full;
	logic             take;
	logic             mem_we;
	logic             mem_re;
	logic             load_done;
	logic             load_empty;
	logic             load_read;

	assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign ring_empty = (rd_ptr_q == wr_ptr_q);
	assign ring_full = (wr_next == rd_ptr_q);
	assign out_free = !out_valid_q || out_ready;
	assign take = cmd_valid && cmd_ready;

	// Command dispatch and next state.
	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		load_done = 1'b0;
		load_empty = 1'b0;
		load_read = 1'b0;
		case (state_q)
			BK_RUN: begin
				case (cmd.kind)
					CMD_EVENT: cmd_ready = 1'b1;
					CMD_DONE:  cmd_ready = out_free;
					CMD_POP:   cmd_ready = out_free;
					default:   cmd_ready = 1'b1;
				endcase
				if (take) begin
					case (cmd.kind)
						CMD_EVENT: mem_we = !ring_full;
						CMD_DONE:  load_done = 1'b1;
						CMD_POP: begin
							if (ring_empty) begin
								load_empty = 1'b1;
							end else begin
								mem_re = 1'b1;
								state_d = BK_READ;
							end
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			BK_READ: begin
				load_read = 1'b1;
				state_d = BK_RUN;
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	// Ring pointers, state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				wr_ptr_q <= wr_next;
			end
			if (mem_re) begin
				rd_ptr_q <= rd_next;
			end
			if (load_done || load_empty || load_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Event memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= {cmd.down, cmd.code};
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_done || load_empty) begin
			out_event_valid_q <= 1'b0;
			out_code_q <= 8'h00;
			out_down_q <= 1'b0;
			out_pending_q <= !ring_empty;
		end else if (load_read) begin
			out_event_valid_q <= 1'b1;
			out_code_q <= rd_data_q[7:0];
			out_down_q <= rd_data_q[8];
			out_pending_q <= !ring_empty;
		end
	end

	assign out_valid = out_valid_q;
	assign out_event_valid = out_event_valid_q;
	assign out_code = out_code_q;
	assign out_down = out_down_q;
	assign out_pending = out_pending_q;

	// The result register is free while a memory read is under way.
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ) |-> !out_valid_q)
		else $error("result register busy during ring read");

	// A completed read always presents a popped event.
	a_read_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ) |=> (out_valid_q && out_event_valid_q))
		else $error("ring read did not produce an event");

	// Ring pointers stay inside the configured depth.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q <= PTR_LAST) && (rd_ptr_q <= PTR_LAST))
		else $error("ring pointer out of range");

endmodule

/* hw/rtl/hid_keyboard_event_queue.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_event_queue: boot keyboard report to key event queue
// Turns each boot keyboard report into press and release events and keeps
// them in a ring; a pop request returns the oldest event.
//
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   modifier_bits, key_0 .. key_5 (56 bits)     action
// m_axis    out  event_keycode, event_is_down, events_pending event_valid
//
// In the scan front end a report passes intake, 18 scan steps (one per cycle
// while the command queue takes events) and completion; a pop passes intake
// and one pop command. The back end runs one command per cycle while the result
// register is free; a pop with an event adds a registered ring memory read.
// Reset clears the previous report, the ring pointers and the command queue.
// A stalled m_axis holds the result; up to four commands still queue behind it.
// ----------------------------------------------------------------------------
module hid_keyboard_event_queue
	import hkeq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // modifier_bits, key_0, .. key_5
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // event_keycode, event_is_down, events_pending
	output logic        m_axis_tuser   // event_valid
);

	logic       front_cmd_valid;
	logic       front_cmd_ready;
	cmd_t       front_cmd;
	logic       back_cmd_valid;
	logic       back_cmd_ready;
	cmd_t       back_cmd;
	logic       event_valid;
	logic [7:0] event_keycode;
	logic       event_is_down;
	logic       events_pending;

	// Request intake and report scan.
	hkeq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_mods   (s_axis_tdata[7:0]),
		.in_keys   (key_set_t'(s_axis_tdata[55:8])),
		.cmd_valid (front_cmd_valid),
		.cmd_ready (front_cmd_ready),
		.cmd       (front_cmd)
	);

	// Decoupling command queue.
	hkeq_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_cmd_valid),
		.push_ready (front_cmd_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_cmd_valid),
		.pop_ready  (back_cmd_ready),
		.pop_cmd    (back_cmd)
	);

	// Event ring and result register.
	hkeq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (back_cmd_valid),
		.cmd_ready       (back_cmd_ready),
		.cmd             (back_cmd),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_event_valid (event_valid),
		.out_code        (event_keycode),
		.out_down        (event_is_down),
		.out_pending     (events_pending)
	);

	// Result packing.
	assign m_axis_tdata = {6'b000000, events_pending, event_is_down, event_keycode};
	assign m_axis_tuser = event_valid;

endmodule
